// ----- rtl/uwb_four_anchor_position_solver_assert.svh -----
// ----------------------------------------------------------------------------
// UWB position solver assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UWB_FOUR_ANCHOR_POSITION_SOLVER_ASSERT_SVH
`define UWB_FOUR_ANCHOR_POSITION_SOLVER_ASSERT_SVH
`ifndef SYNTH
`define UWBPOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UWBPOS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UWBPOS_ASSERT(lbl, prop, msg)
`define UWBPOS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/uwbpos_pkg.sv -----
// ----------------------------------------------------------------------------
// uwbpos_pkg
// Shared types and constants of the UWB four-anchor position solver.
// ----------------------------------------------------------------------------
`default_nettype none
package uwbpos_pkg;

  localparam int unsigned RANGE_FLOOR_DEF   = 100;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_AW          = 2;
  localparam int unsigned CFG_IDX_W         = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_TAG      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CEIL   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_TWO_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_TWO_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ONE_Z = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_4_Z   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HORIZ   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_VERT    = 4'd7;

  typedef struct packed {
    logic [15:0]        own_tag;
    logic [15:0]        range_ceiling;
    logic signed [15:0] anchor_two_x;
    logic signed [15:0] anchor_two_y;
    logic signed [15:0] anchor_one_z;
    logic signed [15:0] anchor_four_z;
    logic [15:0]        baseline_horizontal;
    logic [15:0]        baseline_vertical;
  } cfg_t;

  typedef struct packed {
    logic [15:0] report_tag;
    logic [15:0] range_one;
    logic [15:0] range_two;
    logic [15:0] range_three;
    logic [15:0] range_four;
  } report_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               height_clipped;
  } result_t;

  // clamped ranges of one accepted item
  typedef struct packed {
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] r3;
    logic [15:0] r4;
  } ranges_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ----- rtl/uwb_four_anchor_position_solver.sv -----
// ----------------------------------------------------------------------------
// uwb_four_anchor_position_solver
// Four-anchor UWB trilateration with cosine-rule fractions, fixed point.
// ----------------------------------------------------------------------------
// A fraction whose magnitude reaches 1, or whose denominator is zero, skips its
// divider pass, and a clipped height skips its root pass.
// Flow: the back sequencer finishes one item before it pops the next, sharing one
// bit-serial divider and one root unit; up to 4 items wait in the queue and start
// is taken in any cycle in which busy is low. done_o strobes one cycle, no stall.
// Reset: asynchronous active low; control registers and the configuration return to their defaults.
`default_nettype none
module uwb_four_anchor_position_solver #(
  parameter int unsigned RANGE_FLOOR   = uwbpos_pkg::RANGE_FLOOR_DEF,
  parameter int unsigned FRACTION_BITS = uwbpos_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  uwbpos_pkg::report_t             report_i,
  output logic                            done_o,
  output uwbpos_pkg::result_t             result_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [uwbpos_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [15:0]                      cfg_data_i
);
`include "uwb_four_anchor_position_solver_assert.svh"

  uwbpos_pkg::cfg_t        cfg_q;
  uwbpos_pkg::ranges_t     push_data, head_data;
  uwbpos_pkg::queue_stat_t q_stat;
  logic                    push, pop;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_stat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_tag: 16'd10, range_ceiling: 16'hffff, default: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uwbpos_pkg::CFG_OWN_TAG:      cfg_q.own_tag             <= cfg_data_i;
        uwbpos_pkg::CFG_RANGE_CEIL:   cfg_q.range_ceiling       <= cfg_data_i;
        uwbpos_pkg::CFG_ANCHOR_TWO_X: cfg_q.anchor_two_x        <= cfg_data_i;
        uwbpos_pkg::CFG_ANCHOR_TWO_Y: cfg_q.anchor_two_y        <= cfg_data_i;
        uwbpos_pkg::CFG_ANCHOR_ONE_Z: cfg_q.anchor_one_z        <= cfg_data_i;
        uwbpos_pkg::CFG_ANCHOR_4_Z:   cfg_q.anchor_four_z       <= cfg_data_i;
        uwbpos_pkg::CFG_BASE_HORIZ:   cfg_q.baseline_horizontal <= cfg_data_i;
        uwbpos_pkg::CFG_BASE_VERT:    cfg_q.baseline_vertical   <= cfg_data_i;
        default:                      cfg_q                     <= cfg_q;
      endcase
    end
  end

  uwbpos_front #(.RANGE_FLOOR(RANGE_FLOOR)) u_front (
    .start, .full_i(q_stat.full), .report_i, .cfg_i(cfg_q),
    .push_o(push), .ranges_o(push_data)
  );

  uwbpos_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(push_data),
    .pop_i(pop), .data_o(head_data), .stat_o(q_stat)
  );

  uwbpos_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(q_stat.empty), .item_i(head_data), .cfg_i(cfg_q),
    .pop_o(pop), .done_o, .result_o
  );

  `UWBPOS_ASSERT(a_done_single, done_o |=> !done_o, "result strobe lasted more than one cycle")
  `UWBPOS_ASSERT(a_no_overflow, push |-> !q_stat.full, "push into a full queue")
  `UWBPOS_ASSERT_ALWAYS(a_no_pop_empty, pop |-> !q_stat.empty, "pop from an empty queue")

endmodule
`default_nettype wire

// ----- rtl/uwbpos_queue.sv -----
// ----------------------------------------------------------------------------
// uwbpos_queue
// Small FIFO of clamped range sets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module uwbpos_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  uwbpos_pkg::ranges_t   data_i,
  input  wire                   pop_i,
  output uwbpos_pkg::ranges_t   data_o,
  output uwbpos_pkg::queue_stat_t stat_o
);
  localparam int unsigned AW = uwbpos_pkg::QUEUE_AW;

  uwbpos_pkg::ranges_t mem_q [uwbpos_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (AW+1)'(uwbpos_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= data_i;
        wp_q        <= wp_q + 1'b1;
      end
      if (pop_i) rp_q <= rp_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/uwbpos_front.sv -----
// ----------------------------------------------------------------------------
// uwbpos_front
// Accepts reports, drops foreign tags and clamps the four ranges.
// ----------------------------------------------------------------------------
`default_nettype none
module uwbpos_front #(
  parameter int unsigned RANGE_FLOOR = uwbpos_pkg::RANGE_FLOOR_DEF
) (
  input  wire                 start,
  input  wire                 full_i,
  input  uwbpos_pkg::report_t report_i,
  input  uwbpos_pkg::cfg_t    cfg_i,
  output logic                push_o,
  output uwbpos_pkg::ranges_t ranges_o
);
  localparam logic [15:0] FLOOR = 16'(RANGE_FLOOR);

  function automatic logic [15:0] clamp(input logic [15:0] r, input logic [15:0] ceil_v);
    logic [15:0] v;
    v = (r < FLOOR) ? FLOOR : r;
    return (v > ceil_v) ? ceil_v : v;
  endfunction

  assign push_o = start && !full_i && (report_i.report_tag == cfg_i.own_tag);

  always_comb begin
    ranges_o.r1 = clamp(report_i.range_one,   cfg_i.range_ceiling);
    ranges_o.r2 = clamp(report_i.range_two,   cfg_i.range_ceiling);
    ranges_o.r3 = clamp(report_i.range_three, cfg_i.range_ceiling);
    ranges_o.r4 = clamp(report_i.range_four,  cfg_i.range_ceiling);
  end
endmodule
`default_nettype wire

// ----- rtl/uwbpos_div.sv -----
// ----------------------------------------------------------------------------
// uwbpos_div
// Rounded fraction divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module uwbpos_div #(
  parameter int unsigned FRACTION_BITS = uwbpos_pkg::FRACTION_BITS_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire [33:0]              mag_i,
  input  wire [33:0]              den_i,
  output logic                    done_o,
  output logic [FRACTION_BITS:0]  quot_o
);
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned QW = FB + 1;
  localparam int unsigned DW = 34;
  localparam int unsigned NW = DW + QW;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] low_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [NW-1:0] num_w;
  logic [DW:0]   t_w;
  logic          ge_w;

  // (mag << FB) + den/2; its top DW bits are already below den
  assign num_w = {1'b0, mag_i, {FB{1'b0}}} + NW'(den_i >> 1);
  assign t_w   = {rem_q, low_q[QW-1]};
  assign ge_w  = (t_w >= {1'b0, den_q});
  assign quot_o = low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= num_w[NW-1:QW];
        low_q  <= num_w[QW-1:0];
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= ge_w ? DW'(t_w - {1'b0, den_q}) : t_w[DW-1:0];
        low_q <= {low_q[QW-2:0], ge_w};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/uwbpos_sqrt.sv -----
// ----------------------------------------------------------------------------
// uwbpos_sqrt
// Rounded integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module uwbpos_sqrt #(
  parameter int unsigned FRACTION_BITS = uwbpos_pkg::FRACTION_BITS_DEF,
  localparam int unsigned SP = (FRACTION_BITS + 1 > 16) ? FRACTION_BITS + 1 : 16,
  localparam int unsigned SW = 2 * SP
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire [SW-1:0]  val_i,
  output logic          done_o,
  output logic [SP:0]   root_o
);
  localparam int unsigned CW = $clog2(SP + 1);

  logic [SW-1:0] val_q;
  logic [SP+1:0] rem_q;
  logic [SP-1:0] res_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [SP+3:0] rt_w, trial_w;
  logic          ge_w;

  assign rt_w    = {rem_q, val_q[SW-1 -: 2]};
  assign trial_w = {2'b00, res_q, 2'b01};
  assign ge_w    = (rt_w >= trial_w);
  // remainder is v - res^2; round up when it exceeds res
  assign root_o  = {1'b0, res_q} + (SP+1)'(rem_q > {2'b00, res_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        val_q  <= val_i;
        rem_q  <= '0;
        res_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge_w ? (SP+2)'(rt_w - trial_w) : rt_w[SP+1:0];
        res_q <= {res_q[SP-2:0], ge_w};
        val_q <= {val_q[SW-3:0], 2'b00};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(SP - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/uwbpos_back.sv -----
// ----------------------------------------------------------------------------
// uwbpos_back
// Solver sequencer: fractions, scaling, height projection and output.
// ----------------------------------------------------------------------------
`default_nettype none
module uwbpos_back #(
  parameter int unsigned FRACTION_BITS = uwbpos_pkg::FRACTION_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  uwbpos_pkg::ranges_t item_i,
  input  uwbpos_pkg::cfg_t    cfg_i,
  output logic                pop_o,
  output logic                done_o,
  output uwbpos_pkg::result_t result_o
);
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned QW = FB + 1;
  localparam int unsigned PW = QW + 16;
  localparam int unsigned SP = (FB + 1 > 16) ? FB + 1 : 16;
  localparam int unsigned SW = 2 * SP;
  localparam logic [QW-1:0]   ONE  = {1'b1, {FB{1'b0}}};
  localparam logic [2*FB:0]   ONE2 = {1'b1, {(2*FB){1'b0}}};
  localparam logic [PW-1:0]   HALF = PW'(1) << (FB - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_NUM, S_DIV, S_MUL, S_RND, S_H, S_H2,
    S_P1, S_W1, S_P2, S_W2, S_G2, S_GS, S_W3
  } state_e;

  typedef enum logic [1:0] {PH_Y, PH_Z, PH_G, PH_X} phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [15:0] r1_q, r2_q, r3_q, r4_q, fa_q, fb_q, fc_q, mr_q, p1_q, p2_q;
  logic [31:0] sa_q, sb_q, sc_q, bc_q, r1s_q, r2s_q;
  logic [QW-1:0] fmag_q;
  logic          fsgn_q, fneg_q, clip_q;
  logic [PW-1:0] prod_q;
  logic signed [18:0] y_q, z_q;
  logic [19:0] hm_q;
  logic [39:0] h2_q;
  logic [2*QW-1:0] g2_q;

  logic signed [34:0] num_w;
  logic [33:0]        mag_w, den_w;
  logic               zero_w, sat_w, div_start, div_done;
  logic [QW-1:0]      div_q;
  logic               sq_start, sq_done;
  logic [SW-1:0]      sq_val;
  logic [SP:0]        sq_root;
  logic [PW-1:0]      m_w;
  logic signed [18:0] sm_w, sres_w, x_w;
  logic signed [19:0] h_w, hm_w;
  logic               clip1_w, clip2_w;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767)       return 16'sh7fff;
    else if (v < -19'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  assign num_w  = $signed({3'b000, sb_q}) + $signed({3'b000, sc_q}) - $signed({3'b000, sa_q});
  assign mag_w  = num_w[34] ? 34'(-num_w) : num_w[33:0];
  assign den_w  = {1'b0, bc_q, 1'b0};
  assign zero_w = (fb_q == '0) || (fc_q == '0);
  assign sat_w  = (mag_w >= den_w);
  assign div_start = (state_q == S_NUM) && !zero_w && !sat_w;

  assign m_w    = (prod_q + HALF) >> FB;
  assign sm_w   = {2'b00, m_w[16:0]};
  assign sres_w = fsgn_q ? -sm_w : sm_w;
  assign x_w    = 19'(cfg_i.anchor_two_x) + sres_w;

  assign h_w  = 20'(z_q) - 20'(cfg_i.anchor_one_z);
  assign hm_w = h_w[19] ? -h_w : h_w;
  assign clip1_w = (hm_q > {4'b0000, r1_q});
  assign clip2_w = (hm_q > {4'b0000, r2_q});

  always_comb begin
    sq_start = 1'b0;
    sq_val   = SW'(r1s_q - h2_q[31:0]);
    case (state_q)
      S_P1: sq_start = !clip1_w;
      S_P2: begin
        sq_start = !clip2_w;
        sq_val   = SW'(r2s_q - h2_q[31:0]);
      end
      S_GS: begin
        sq_start = 1'b1;
        sq_val   = SW'(ONE2 - (2*FB+1)'(g2_q));
      end
      default: sq_start = 1'b0;
    endcase
  end

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  uwbpos_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .mag_i(mag_w), .den_i(den_w),
    .done_o(div_done), .quot_o(div_q)
  );

  uwbpos_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sq_start), .val_i(sq_val),
    .done_o(sq_done), .root_o(sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_Y;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (!empty_i) begin
          r1_q <= item_i.r1; r2_q <= item_i.r2;
          r3_q <= item_i.r3; r4_q <= item_i.r4;
          fa_q <= item_i.r1; fb_q <= item_i.r2; fc_q <= cfg_i.baseline_horizontal;
          clip_q  <= 1'b0;
          phase_q <= PH_Y;
          state_q <= S_SQ;
        end
        S_SQ: begin
          sa_q <= fa_q * fa_q;
          sb_q <= fb_q * fb_q;
          sc_q <= fc_q * fc_q;
          bc_q <= fb_q * fc_q;
          state_q <= S_NUM;
        end
        S_NUM: begin
          fneg_q <= num_w[34];
          if (zero_w || sat_w) begin
            fmag_q <= ONE;
            fsgn_q <= !zero_w && num_w[34];
            mr_q   <= (phase_q == PH_Y) ? r2_q : r4_q;
            state_q <= (phase_q == PH_G) ? S_G2 : S_MUL;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          fmag_q <= div_q;
          fsgn_q <= fneg_q;
          mr_q   <= (phase_q == PH_Y) ? r2_q : r4_q;
          state_q <= (phase_q == PH_G) ? S_G2 : S_MUL;
        end
        S_MUL: begin
          prod_q  <= mr_q * fmag_q;
          state_q <= S_RND;
        end
        S_RND: begin
          case (phase_q)
            PH_Y: begin
              y_q  <= 19'(cfg_i.anchor_two_y) + sres_w;
              fa_q <= r3_q; fb_q <= r4_q; fc_q <= cfg_i.baseline_vertical;
              phase_q <= PH_Z;
              state_q <= S_SQ;
            end
            PH_Z: begin
              z_q     <= 19'(cfg_i.anchor_four_z) + sres_w;
              state_q <= S_H;
            end
            PH_X: begin
              result_o.pos_x <= sat16(x_w);
              result_o.pos_y <= sat16(y_q);
              result_o.pos_z <= sat16(z_q);
              result_o.height_clipped <= clip_q;
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_H: begin
          hm_q  <= hm_w;
          r1s_q <= r1_q * r1_q;
          r2s_q <= r2_q * r2_q;
          state_q <= S_H2;
        end
        S_H2: begin
          h2_q    <= hm_q * hm_q;
          state_q <= S_P1;
        end
        S_P1: if (clip1_w) begin
          clip_q <= 1'b1;
          p1_q   <= '0;
          state_q <= S_P2;
        end else begin
          state_q <= S_W1;
        end
        S_W1: if (sq_done) begin
          p1_q    <= sq_root[15:0];
          state_q <= S_P2;
        end
        S_P2: if (clip2_w) begin
          clip_q <= 1'b1;
          p2_q   <= '0;
          fa_q <= p1_q; fb_q <= '0; fc_q <= cfg_i.baseline_horizontal;
          phase_q <= PH_G;
          state_q <= S_SQ;
        end else begin
          state_q <= S_W2;
        end
        S_W2: if (sq_done) begin
          p2_q <= sq_root[15:0];
          fa_q <= p1_q; fb_q <= sq_root[15:0]; fc_q <= cfg_i.baseline_horizontal;
          phase_q <= PH_G;
          state_q <= S_SQ;
        end
        S_G2: begin
          g2_q    <= fmag_q * fmag_q;
          state_q <= S_GS;
        end
        S_GS: state_q <= S_W3;
        S_W3: if (sq_done) begin
          fmag_q  <= sq_root[QW-1:0];
          fsgn_q  <= 1'b0;
          mr_q    <= p2_q;
          phase_q <= PH_X;
          state_q <= S_MUL;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
